FILE: sv/cla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line assembler package
// Shared constants, state encodings and the control and status structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package cla_pkg;

  localparam int LINE_CAPACITY = 32;
  localparam int STORE_DEPTH   = LINE_CAPACITY + 2;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int CNT_W         = $clog2(STORE_DEPTH + 1);
  localparam int BYTE_W        = 8;

  localparam logic [BYTE_W-1:0] CODE_ESC     = 8'd27;
  localparam logic [BYTE_W-1:0] CODE_BS      = 8'd127;
  localparam logic [BYTE_W-1:0] CODE_BRACKET = 8'h5B;
  localparam logic [BYTE_W-1:0] CODE_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CODE_LF      = 8'h0A;

  typedef enum logic [1:0] {
    ESC_IDLE    = 2'd0,
    ESC_SEEN    = 2'd1,
    ESC_BRACKET = 2'd2
  } esc_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_PUT_LF = 3'd1,
    ST_READ   = 3'd2,
    ST_LOAD   = 3'd3,
    ST_SEND   = 3'd4
  } cla_state_e;

  typedef struct packed {
    logic accept;
    logic put_lf;
    logic rd_en;
    logic load_out;
    logic sent;
  } cla_cmd_t;

  typedef struct packed {
    logic line_done;
    logic last;
  } cla_status_t;

endpackage

FILE: sv/cla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 34
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/cla_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line assembler controller
// Sequences word intake, the trailing line feed write and the readout of a
// completed line.
// ----------------------------------------------------------------------------
module cla_ctrl
  import cla_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  output logic        line_valid_o,
  input  logic        line_stall_i,
  input  cla_status_t status_i,
  output cla_cmd_t    cmd_o
);

  cla_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    rx_stall_o   = 1'b1;
    line_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        rx_stall_o = 1'b0;
        if (rx_valid_i) begin
          cmd_o.accept = 1'b1;
          if (status_i.line_done) begin
            state_d = ST_PUT_LF;
          end
        end
      end
      ST_PUT_LF: begin
        cmd_o.put_lf = 1'b1;
        state_d      = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_out = 1'b1;
        state_d        = ST_SEND;
      end
      ST_SEND: begin
        line_valid_o = 1'b1;
        if (!line_stall_i) begin
          cmd_o.sent = 1'b1;
          state_d    = status_i.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/cla_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line assembler datapath
// Escape filter, line store with fill count, overrun flag and the output
// register for the line readout.
// ----------------------------------------------------------------------------
module cla_dp
  import cla_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  cla_cmd_t          cmd_i,
  output cla_status_t       status_o,
  output logic [BYTE_W-1:0] line_byte_o,
  output logic              line_last_o,
  output logic              line_overrun_o
);

  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
  esc_phase_e        phase_q, phase_d;
  logic              ovr_q, ovr_d;
  logic              full;
  logic [BYTE_W-1:0] b_eff;
  esc_phase_e        phase_new;
  logic              drop;
  logic              keep;
  logic              ram_we;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;
  logic              out_ovr_q;
  logic              rd_last;

  assign full  = fill_q >= CNT_W'(LINE_CAPACITY);
  assign b_eff = full ? CODE_CR : rx_byte_i;

  always_comb begin
    phase_new = ESC_IDLE;
    drop      = 1'b0;
    case (phase_q)
      ESC_SEEN: begin
        if (b_eff == CODE_BRACKET) begin
          phase_new = ESC_BRACKET;
          drop      = 1'b1;
        end
      end
      ESC_BRACKET: begin
        drop = 1'b1;
      end
      default: begin
        phase_new = ESC_IDLE;
      end
    endcase
    if (!drop && b_eff == CODE_ESC) begin
      phase_new = ESC_SEEN;
      drop      = 1'b1;
    end
  end

  assign keep               = !drop && (b_eff != CODE_LF);
  assign status_o.line_done = keep && (b_eff == CODE_CR);
  assign rd_last            = (CNT_W'(rd_ptr_q) + CNT_W'(1)) == fill_q;
  assign status_o.last      = out_last_q;

  assign ram_we    = (cmd_i.accept && keep) || cmd_i.put_lf;
  assign ram_wdata = cmd_i.put_lf ? CODE_LF : b_eff;

  cla_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q[ADDR_W-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    fill_d   = fill_q;
    rd_ptr_d = rd_ptr_q;
    phase_d  = phase_q;
    ovr_d    = ovr_q;
    if (cmd_i.accept) begin
      phase_d = phase_new;
      if (full) begin
        ovr_d = 1'b1;
      end
      if (keep) begin
        if (b_eff == CODE_BS) begin
          fill_d = (fill_q == '0) ? '0 : fill_q - CNT_W'(1);
        end else begin
          fill_d = fill_q + CNT_W'(1);
        end
      end
    end
    if (cmd_i.put_lf) begin
      fill_d = fill_q + CNT_W'(1);
    end
    if (cmd_i.sent) begin
      if (out_last_q) begin
        fill_d   = '0;
        rd_ptr_d = '0;
        ovr_d    = 1'b0;
      end else begin
        rd_ptr_d = rd_ptr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      rd_ptr_q   <= '0;
      phase_q    <= ESC_IDLE;
      ovr_q      <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      rd_ptr_q <= rd_ptr_d;
      phase_q  <= phase_d;
      ovr_q    <= ovr_d;
      if (cmd_i.load_out) begin
        out_last_q <= rd_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_byte_q <= ram_rdata;
      out_ovr_q  <= ovr_q;
    end
  end

  assign line_byte_o    = out_byte_q;
  assign line_last_o    = out_last_q;
  assign line_overrun_o = out_ovr_q;

endmodule

FILE: sv/command_line_assembler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line assembler
// Gathers received serial bytes into a command line and emits the completed
// line, followed by CR and LF, one word at a time.
//
// The input channel (rx_valid_i, rx_stall_o, rx_byte_i) takes one received
// byte per word. While a line is assembled, a word is taken every cycle;
// words that do not complete a line produce no output.
// A carriage return (or the forced one after overrun) completes the line.
// The output channel (line_valid_o, line_stall_i) then carries the line
// bytes, CR and LF, with line_last_o on the LF and line_overrun_o on every
// word of a line that was cut short. The first output word follows the
// completing input word through the PUT_LF, READ and LOAD states; each
// further word passes through READ and LOAD again after the previous one
// is taken, set by the single read port of the line store and its
// registered read data. The input stays stalled until the LF is taken.
// A stall on the output holds the current word in place. Reset empties the
// line, clears the escape filter and the overrun flag; no clearing pass.
// ----------------------------------------------------------------------------
module command_line_assembler_unit
  import cla_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_stall_o,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output logic              line_valid_o,
  input  logic              line_stall_i,
  output logic [BYTE_W-1:0] line_byte_o,
  output logic              line_last_o,
  output logic              line_overrun_o
);

  cla_cmd_t    cmd;
  cla_status_t status;

  cla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_stall_o  (rx_stall_o),
    .line_valid_o(line_valid_o),
    .line_stall_i(line_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cla_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .line_byte_o   (line_byte_o),
    .line_last_o   (line_last_o),
    .line_overrun_o(line_overrun_o)
  );

  a_no_intake_while_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_valid_o |-> rx_stall_o)
    else $error("input taken while a line word is pending");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_valid_o && !line_stall_i && line_last_o) |=> !line_valid_o)
    else $error("output still valid after the last word of a line");

  a_next_word_same_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_valid_o && !line_stall_i && !line_last_o) |->
      ##3 (line_valid_o && line_overrun_o == $past(line_overrun_o, 3)))
    else $error("line readout broke off or overrun flag changed within a line");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line assembler testbench
// Feeds received bytes into the assembler and checks every emitted line word
// against a line predictor kept in a scoreboard. A short directed sequence
// covers the escape filter, backspace and empty lines. Random well-formed
// lines, long overrun lines and noise follow, with random idling on both
// channels, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb;
  import cla_pkg::*;

  localparam int RANDOM_ITEMS = 155;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              overrun;
  } line_word_t;

  class line_scoreboard;
    logic [BYTE_W-1:0] chars [STORE_DEPTH];
    int                fill;
    esc_phase_e        phase;
    logic              overrun;
    line_word_t        pending_words [$];
    int                errors;

    function new();
      fill    = 0;
      phase   = ESC_IDLE;
      overrun = 1'b0;
      errors  = 0;
    endfunction

    function void store_char(logic [BYTE_W-1:0] c);
      if (fill < STORE_DEPTH) begin
        chars[fill] = c;
        fill++;
      end
    endfunction

    function void note_rx_byte(logic [BYTE_W-1:0] rx);
      logic [BYTE_W-1:0] c;
      bit                drop;
      line_word_t        w;
      c    = rx;
      drop = 0;
      if (fill >= LINE_CAPACITY) begin
        c       = CODE_CR;
        overrun = 1'b1;
      end
      case (phase)
        ESC_SEEN: begin
          if (c == CODE_BRACKET) begin
            phase = ESC_BRACKET;
            drop  = 1;
          end else begin
            phase = ESC_IDLE;
          end
        end
        ESC_BRACKET: begin
          phase = ESC_IDLE;
          drop  = 1;
        end
        default: begin
          phase = ESC_IDLE;
        end
      endcase
      if (!drop && c == CODE_ESC) begin
        phase = ESC_SEEN;
        drop  = 1;
      end
      if (drop || c == CODE_LF) return;
      store_char(c);
      if (c == CODE_CR) begin
        store_char(CODE_LF);
        for (int k = 0; k < fill; k++) begin
          w.data    = chars[k];
          w.last    = (k + 1 == fill);
          w.overrun = overrun;
          pending_words.push_back(w);
        end
        fill    = 0;
        overrun = 1'b0;
        return;
      end
      if (c == CODE_BS) begin
        fill--;
        if (fill > 0) fill--;
      end
    endfunction

    function void check_line_word(logic [BYTE_W-1:0] data, logic last, logic ovr);
      line_word_t w;
      if (pending_words.size() == 0) begin
        $error("line word %0h with no expected word", data);
        errors++;
        return;
      end
      w = pending_words.pop_front();
      if (data !== w.data) begin
        $error("line_byte: expected %0h, got %0h", w.data, data);
        errors++;
      end
      if (last !== w.last) begin
        $error("line_last: expected %0b, got %0b", w.last, last);
        errors++;
      end
      if (ovr !== w.overrun) begin
        $error("line_overrun: expected %0b, got %0b", w.overrun, ovr);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              rx_valid_i     = 1'b0;
  logic              rx_stall_o;
  logic [BYTE_W-1:0] rx_byte_i      = '0;
  logic              line_valid_o;
  logic              line_stall_i   = 1'b0;
  logic [BYTE_W-1:0] line_byte_o;
  logic              line_last_o;
  logic              line_overrun_o;

  line_scoreboard sb = new();
  bit quiet_in      = 0;
  bit quiet_out     = 0;
  bit hold_request  = 0;
  int random_sent   = 0;
  int cycle_count   = 0;

  command_line_assembler_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_stall_o     (rx_stall_o),
    .rx_byte_i      (rx_byte_i),
    .line_valid_o   (line_valid_o),
    .line_stall_i   (line_stall_i),
    .line_byte_o    (line_byte_o),
    .line_last_o    (line_last_o),
    .line_overrun_o (line_overrun_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && line_valid_o && !line_stall_i) begin
      sb.check_line_word(line_byte_o, line_last_o, line_overrun_o);
    end
  end

  always begin
    @(posedge clk_i);
    if (hold_request) begin
      line_stall_i <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_request = 0;
    end
    line_stall_i <= quiet_out ? 1'b0 : ($urandom_range(99) < 8);
  end

  task automatic send_rx(input logic [BYTE_W-1:0] b);
    if (!quiet_in && $urandom_range(99) < 8) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    sb.note_rx_byte(b);
    if (b != CODE_LF) random_sent++;
  endtask

  task automatic drain_lines();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_char();
    int r;
    r = $urandom_range(99);
    if (r < 65) begin
      send_rx(8'($urandom_range(32, 126)));
    end else if (r < 75) begin
      send_rx(CODE_BS);
    end else if (r < 80) begin
      send_rx(CODE_LF);
    end else if (r < 85) begin
      send_rx(CODE_ESC);
      send_rx(CODE_BRACKET);
      send_rx(8'($urandom_range(65, 68)));
    end else if (r < 90) begin
      send_rx(CODE_ESC);
      send_rx(8'($urandom_range(0, 255)));
    end else begin
      send_rx(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_line(input int len);
    repeat (len) send_random_char();
    send_rx(CODE_CR);
  endtask

  task automatic send_long_line();
    repeat ($urandom_range(32, 36)) send_rx(8'($urandom_range(32, 126)));
    send_rx(CODE_CR);
  endtask

  initial begin
    int pass_no;
    int r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_rx(CODE_BS);
    send_rx(8'h41);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(CODE_BS);
    send_rx(CODE_LF);
    send_rx(CODE_ESC);
    send_rx(CODE_BRACKET);
    send_rx(8'h41);
    send_rx(CODE_ESC);
    send_rx(8'h78);
    send_rx(CODE_ESC);
    send_rx(CODE_ESC);
    send_rx(CODE_BRACKET);
    send_rx(8'h42);
    send_rx(CODE_ESC);
    send_rx(CODE_BS);
    send_rx(CODE_ESC);
    send_rx(CODE_CR);
    send_rx(CODE_CR);
    send_rx(8'h55);
    send_rx(8'hAA);
    send_rx(CODE_CR);
    drain_lines();

    random_sent = 0;
    pass_no     = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pass_no++;
      quiet_in  = (pass_no >= 7 && pass_no < 12);
      quiet_out = quiet_in;
      if (pass_no == 5) begin
        hold_request = 1;
        send_line(10);
        repeat (6) send_random_char();
      end else if (pass_no == 12) begin
        drain_lines();
      end else begin
        r = $urandom_range(99);
        if (r < 60) begin
          send_line($urandom_range(0, 12));
        end else if (r < 70) begin
          send_long_line();
        end else if (r < 85) begin
          repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 3)) send_random_char();
          send_rx(CODE_ESC);
        end
      end
    end
    send_rx(CODE_CR);
    quiet_in  = 0;
    quiet_out = 0;

    drain_lines();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/cla_pkg.sv
sv/cla_ram.sv
sv/cla_ctrl.sv
sv/cla_dp.sv
sv/command_line_assembler_unit.sv
tb/tb.sv
